@@ rtl/drr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_pkg
// Shared types for the duration ratio reducer: controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package drr_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_REDUCE,
		ST_DIVIDE,
		ST_DONE
	} drr_state_t;

	typedef struct packed {
		logic load;         // capture a new request
		logic align_step;   // strip a common factor of two
		logic reduce_step;  // one binary GCD step
		logic div_start;    // form the divisor, clear remainders
		logic div_step;     // one quotient bit in both lanes
		logic out_load;     // move the result to the output register
	} drr_cmd_t;

	typedef struct packed {
		logic zero_in;      // either time was zero
		logic both_even;
		logic gcd_equal;
		logic div_last;
	} drr_status_t;

endpackage

@@ rtl/drr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_datapath
// Binary GCD registers and two restoring divider lanes sharing one divisor,
// plus the output register.
// ----------------------------------------------------------------------------
module drr_datapath #(
	parameter int TIME_BITS = 16
) (
	input  logic                     clk,
	input  drr_pkg::drr_cmd_t        cmd,
	output drr_pkg::drr_status_t     status,
	input  logic [TIME_BITS-1:0]     insp_time_ms,
	input  logic [TIME_BITS-1:0]     exp_time_ms,
	output logic [TIME_BITS-1:0]     insp_term,
	output logic [TIME_BITS-1:0]     exp_term,
	output logic [TIME_BITS-1:0]     common_divisor,
	output logic                     invalid
);

	localparam int W  = TIME_BITS;
	localparam int KW = $clog2(TIME_BITS);

	logic [W-1:0]  a_q, b_q, g_q;
	logic [W-1:0]  quo_i_q, quo_e_q;
	logic [W-1:0]  rem_i_q, rem_e_q;
	logic [KW-1:0] k_q, cnt_q;
	logic          inv_q;

	logic [W:0]    trial_i, trial_e, diff_i, diff_e;
	logic [W-1:0]  a_minus_b, b_minus_a;

	assign a_minus_b = a_q - b_q;
	assign b_minus_a = b_q - a_q;

	assign trial_i = {rem_i_q, quo_i_q[W-1]};
	assign trial_e = {rem_e_q, quo_e_q[W-1]};
	assign diff_i  = trial_i - {1'b0, g_q};
	assign diff_e  = trial_e - {1'b0, g_q};

	assign status.zero_in   = inv_q;
	assign status.both_even = ~a_q[0] & ~b_q[0];
	assign status.gcd_equal = (a_q == b_q);
	assign status.div_last  = (cnt_q == KW'(W - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q     <= insp_time_ms;
			b_q     <= exp_time_ms;
			quo_i_q <= insp_time_ms;
			quo_e_q <= exp_time_ms;
			k_q     <= '0;
			inv_q   <= (insp_time_ms == '0) || (exp_time_ms == '0);
		end else if (cmd.align_step) begin
			a_q <= a_q >> 1;
			b_q <= b_q >> 1;
			k_q <= k_q + KW'(1);
		end else if (cmd.reduce_step) begin
			// Both operands stay nonzero: odd minus a different odd is even and nonzero.
			if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= a_minus_b >> 1;
			end else begin
				b_q <= b_minus_a >> 1;
			end
		end else if (cmd.div_start) begin
			g_q     <= a_q << k_q;
			rem_i_q <= '0;
			rem_e_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + KW'(1);
			if (!diff_i[W]) begin
				rem_i_q <= diff_i[W-1:0];
				quo_i_q <= {quo_i_q[W-2:0], 1'b1};
			end else begin
				rem_i_q <= trial_i[W-1:0];
				quo_i_q <= {quo_i_q[W-2:0], 1'b0};
			end
			if (!diff_e[W]) begin
				rem_e_q <= diff_e[W-1:0];
				quo_e_q <= {quo_e_q[W-2:0], 1'b1};
			end else begin
				rem_e_q <= trial_e[W-1:0];
				quo_e_q <= {quo_e_q[W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			insp_term      <= inv_q ? '0 : quo_i_q;
			exp_term       <= inv_q ? '0 : quo_e_q;
			common_divisor <= inv_q ? '0 : g_q;
			invalid        <= inv_q;
		end
	end

endmodule

@@ rtl/drr_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_controller
// Sequencer for align, reduce and divide phases, and the output valid flag.
// ----------------------------------------------------------------------------
module drr_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  drr_pkg::drr_status_t  status,
	output drr_pkg::drr_cmd_t     cmd
);

	drr_pkg::drr_state_t state_q, state_nxt;
	logic                out_valid_q;
	logic                out_free;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			drr_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = drr_pkg::ST_ALIGN;
			end
			drr_pkg::ST_ALIGN: begin
				if (status.zero_in) state_nxt = drr_pkg::ST_DONE;
				else if (!status.both_even) state_nxt = drr_pkg::ST_REDUCE;
			end
			drr_pkg::ST_REDUCE: begin
				if (status.gcd_equal) state_nxt = drr_pkg::ST_DIVIDE;
			end
			drr_pkg::ST_DIVIDE: begin
				if (status.div_last) state_nxt = drr_pkg::ST_DONE;
			end
			drr_pkg::ST_DONE: begin
				if (out_free) state_nxt = drr_pkg::ST_IDLE;
			end
			default: state_nxt = drr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			drr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			drr_pkg::ST_ALIGN: begin
				cmd.align_step = !status.zero_in && status.both_even;
			end
			drr_pkg::ST_REDUCE: begin
				cmd.div_start   = status.gcd_equal;
				cmd.reduce_step = !status.gcd_equal;
			end
			drr_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			drr_pkg::ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/duration_ratio_reducer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_ratio_reducer_top
// Reduces an inspiration to expiration time ratio to lowest terms.
// ----------------------------------------------------------------------------
// Each request carries two times; the block returns both divided by their
// greatest common divisor, and the divisor. If either time is zero, invalid
// is set and the other fields are zero. One request is processed at a time:
// a binary GCD strips common factors of two, then reduces with one
// subtract-or-shift per cycle, and every step drops at least one bit from
// the two operands. Two restoring divider lanes then produce one quotient bit
// per cycle. The processing time is set by the iterative GCD and the serial
// divide. A zero time goes from the align phase straight to the done state,
// skipping reduce and divide. The result sits in an output register,
// so a new request is taken while the previous result waits for out_ready.
// ----------------------------------------------------------------------------
module duration_ratio_reducer_top #(
	parameter int TIME_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_BITS-1:0] insp_time_ms,
	input  logic [TIME_BITS-1:0] exp_time_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [TIME_BITS-1:0] insp_term,
	output logic [TIME_BITS-1:0] exp_term,
	output logic [TIME_BITS-1:0] common_divisor,
	output logic                 invalid
);

	drr_pkg::drr_cmd_t    cmd;
	drr_pkg::drr_status_t status;

	drr_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	drr_datapath #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.status         (status),
		.insp_time_ms   (insp_time_ms),
		.exp_time_ms    (exp_time_ms),
		.insp_term      (insp_term),
		.exp_term       (exp_term),
		.common_divisor (common_divisor),
		.invalid        (invalid)
	);

endmodule

@@ rtl/drr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drr_checker
// Port-level checks for the duration ratio reducer.
// ----------------------------------------------------------------------------
module drr_checker #(
	parameter int TIME_BITS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [TIME_BITS-1:0] insp_time_ms,
	input logic [TIME_BITS-1:0] exp_time_ms,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [TIME_BITS-1:0] insp_term,
	input logic [TIME_BITS-1:0] exp_term,
	input logic [TIME_BITS-1:0] common_divisor,
	input logic                 invalid
);

	// A waiting request must hold until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(insp_time_ms)
			&& $stable(exp_time_ms))
		else $error("request changed while waiting");

	// A stalled result must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(insp_term)
			&& $stable(exp_term) && $stable(common_divisor) && $stable(invalid))
		else $error("result changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid |-> insp_term == '0 && exp_term == '0
			&& common_divisor == '0)
		else $error("invalid result carries nonzero fields");

	a_valid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |-> common_divisor != '0 && insp_term != '0
			&& exp_term != '0)
		else $error("valid result has a zero field");

	// Reduced terms cannot both be even.
	a_lowest_terms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid |-> insp_term[0] || exp_term[0])
		else $error("result not in lowest terms");

endmodule

bind duration_ratio_reducer_top drr_checker #(.TIME_BITS(TIME_BITS)) u_drr_checker (.*);
